FILE: design/tdwt_pkg.sv
// ----------------------------------------------------------------------------
// tdwt_pkg
// shared types and codes for the tick deadline wait table
// ----------------------------------------------------------------------------
`default_nettype none

package tdwt_pkg;

    // number of task slots
    localparam int TASKS = 8;
    localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [31:0]      t_time;

    // input mode codes
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_UNTIL = 2'd1;
    localparam logic [1:0] MODE_DELAY = 2'd2;

    // result kind codes
    localparam logic [1:0] KIND_BLOCKED   = 2'd0;
    localparam logic [1:0] KIND_READY     = 2'd1;
    localparam logic [1:0] KIND_RELEASED  = 2'd2;
    localparam logic [1:0] KIND_TICK_DONE = 2'd3;

    // shared unit outputs
    typedef struct packed {
        t_time sum;
        logic  ge;
    } t_unit_res;

endpackage

`default_nettype wire

FILE: design/tdwt_unit.sv
// ----------------------------------------------------------------------------
// tdwt_unit
// shared 32-bit add and unsigned compare unit used by the sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module tdwt_unit (
    input  var tdwt_pkg::t_time     i_op_a,
    input  var tdwt_pkg::t_time     i_op_b,
    output tdwt_pkg::t_unit_res     o_res
);

    // wrapping sum and a >= b
    always_comb begin
        o_res.sum = i_op_a + i_op_b;
        o_res.ge  = (i_op_a >= i_op_b);
    end

endmodule

`default_nettype wire

FILE: design/tick_deadline_wait_table.sv
// ----------------------------------------------------------------------------
// tick_deadline_wait_table
// millisecond uptime with one deadline slot per task; ticks release due tasks
// ----------------------------------------------------------------------------
//
//  channel   signals                                       direction
//  command   start, busy, i_mode, i_task_id, i_time_value  in  (transfer: start & !busy)
//  result    o_valid, o_kind, o_task_id_out,               out (one-cycle strobe)
//            o_uptime_now, o_last
//
//  a tick steps through the transfer, the uptime increment, a scan of every slot
//  in turn through the single shared comparator, and tick done.
//  a wait until deadline goes from the transfer straight to the compare; a wait
//  for delay first adds the delay to the uptime, then compares.
//  mode three is accepted and gives no result.
//  synchronous active-low reset clears uptime, waiting flags and sequencer.
//  the receiver cannot stall; each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tick_deadline_wait_table (
    input  var logic        i_clk,
    input  var logic        i_rst_n,
    input  var logic        start,
    output logic            busy,
    input  var logic [1:0]  i_mode,
    input  var logic [2:0]  i_task_id,
    input  var logic [31:0] i_time_value,
    output logic            o_valid,
    output logic [1:0]      o_kind,
    output logic [2:0]      o_task_id_out,
    output logic [31:0]     o_uptime_now,
    output logic            o_last
);

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INC  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;
    localparam logic [2:0] S_ADD  = 3'd4;
    localparam logic [2:0] S_CMP  = 3'd5;

    localparam tdwt_pkg::t_idx LAST_IDX = tdwt_pkg::t_idx'(tdwt_pkg::TASKS - 1);

    logic [2:0]                 r_state;
    tdwt_pkg::t_time            r_uptime;
    logic [tdwt_pkg::TASKS-1:0] r_waiting;
    tdwt_pkg::t_time            r_deadlines [tdwt_pkg::TASKS];
    tdwt_pkg::t_idx             r_idx;
    logic [2:0]                 r_task;
    tdwt_pkg::t_time            r_tval;
    logic                       r_task_ok;

    tdwt_pkg::t_time            n_op_a;
    tdwt_pkg::t_time            n_op_b;
    tdwt_pkg::t_unit_res        w_res;
    tdwt_pkg::t_idx             w_task_idx;
    logic                       w_accept;

    assign busy       = (r_state != S_IDLE);
    assign w_accept   = start && !busy;
    assign w_task_idx = tdwt_pkg::t_idx'(r_task);

    // operand select for the shared unit
    always_comb begin
        n_op_a = r_uptime;
        case (r_state)
            S_INC:   n_op_b = 32'd1;
            S_SCAN:  n_op_b = r_deadlines[r_idx];
            S_ADD:   n_op_b = r_tval;
            S_CMP:   n_op_b = r_tval;
            default: n_op_b = 32'd1;
        endcase
    end

    tdwt_unit u_unit (
        .i_op_a (n_op_a),
        .i_op_b (n_op_b),
        .o_res  (w_res)
    );

    // deadline slots, written only when a request blocks
    always_ff @(posedge i_clk) begin
        if (r_state == S_CMP && r_task_ok && !w_res.ge) begin
            r_deadlines[w_task_idx] <= r_tval;
        end
    end

    // command capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_task    <= i_task_id;
            r_tval    <= i_time_value;
            r_task_ok <= (32'(i_task_id) < 32'(tdwt_pkg::TASKS));
        end else if (r_state == S_ADD) begin
            r_tval <= w_res.sum;
        end
    end

    // sequencer, uptime, waiting flags and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_uptime  <= '0;
            r_waiting <= '0;
            r_idx     <= '0;
            o_valid   <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (w_accept) begin
                        case (i_mode)
                            tdwt_pkg::MODE_TICK:  r_state <= S_INC;
                            tdwt_pkg::MODE_UNTIL: r_state <= S_CMP;
                            tdwt_pkg::MODE_DELAY: r_state <= S_ADD;
                            default:              r_state <= S_IDLE;
                        endcase
                    end
                end
                S_INC: begin
                    r_uptime <= w_res.sum;
                    r_state  <= S_SCAN;
                end
                S_SCAN: begin
                    // release one due slot per cycle
                    if (r_waiting[r_idx] && w_res.ge) begin
                        r_waiting[r_idx] <= 1'b0;
                        o_valid <= 1'b1;
                    end
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DONE: begin
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_ADD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    // blocked when deadline is later than uptime
                    if (r_task_ok) begin
                        r_waiting[w_task_idx] <= !w_res.ge;
                    end
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        o_uptime_now <= r_uptime;
        case (r_state)
            S_INC: begin
                o_uptime_now <= w_res.sum;
            end
            S_SCAN: begin
                o_kind        <= tdwt_pkg::KIND_RELEASED;
                o_task_id_out <= 3'(r_idx);
                o_last        <= 1'b0;
            end
            S_DONE: begin
                o_kind        <= tdwt_pkg::KIND_TICK_DONE;
                o_task_id_out <= '0;
                o_last        <= 1'b1;
            end
            S_CMP: begin
                o_kind        <= (r_task_ok && !w_res.ge) ? tdwt_pkg::KIND_BLOCKED
                                                          : tdwt_pkg::KIND_READY;
                o_task_id_out <= r_task;
                o_last        <= 1'b1;
            end
            default: begin
                o_last <= 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire
